[sv/bgbs_pkg.sv]
package bgbs_pkg;

	localparam int DELAY_W = 16;
	localparam int INDEX_W = 2;
	localparam int MODE_W  = 2;
	localparam int NUM_DELAYS = 4;

	// slave tdata: button_level in bit 0, padded to one byte
	localparam int S_TDATA_W = 8;
	// master tdata: led_level, mode, current_delay, delay_index, reverse
	localparam int M_FIELDS_W = 1 + MODE_W + DELAY_W + INDEX_W + 1;
	localparam int M_TDATA_W  = ((M_FIELDS_W + 7) / 8) * 8;

	localparam int APB_ADDR_W = 5;
	localparam int APB_DATA_W = 32;

	typedef enum logic [2:0] {
		REG_DELAY_0   = 3'd0,
		REG_DELAY_1   = 3'd1,
		REG_DELAY_2   = 3'd2,
		REG_DELAY_3   = 3'd3,
		REG_HOLD_THR  = 3'd4,
		REG_CLICK_GAP = 3'd5
	} reg_idx_t;

	typedef enum logic [MODE_W-1:0] {
		GEST_NONE       = 2'd0,
		GEST_ONE_CLICK  = 2'd1,
		GEST_TWO_CLICKS = 2'd2,
		GEST_HELD       = 2'd3
	} mode_t;

	localparam logic [DELAY_W-1:0] DELAY_0_RST   = 16'd250;
	localparam logic [DELAY_W-1:0] DELAY_1_RST   = 16'd500;
	localparam logic [DELAY_W-1:0] DELAY_2_RST   = 16'd1000;
	localparam logic [DELAY_W-1:0] DELAY_3_RST   = 16'd2000;
	localparam logic [DELAY_W-1:0] HOLD_THR_RST  = 16'd100;
	localparam logic [DELAY_W-1:0] CLICK_GAP_RST = 16'd50;

	localparam logic [1:0] CLICKS_MAX = 2'd2;

	function automatic logic [INDEX_W-1:0] next_index(logic [INDEX_W-1:0] idx, logic down);
		logic [INDEX_W-1:0] r;
		r = down ? (idx - 1'b1) : (idx + 1'b1);
		return r;
	endfunction

endpackage

[sv/button_gesture_blink_sequencer_top.sv]
// Channel  | Dir | Handshake                 | Payload
// ---------+-----+---------------------------+---------------------------------------------
// s_*      | in  | s_tvalid / s_tready       | s_tdata[0] button_level, [7:1] zero
// m_*      | out | m_tvalid / m_tready       | m_tdata led/mode/delay/index/reverse
// APB      | in  | psel & penable & pwrite   | 6 regs at 4*i: delay_0..3, hold_thr, click_gap
//
// One button word per cycle unless m_tready stalls; one registered result word per button word.
// All timers and gesture state update in a single combinational pass from the
// state registers into the state and result registers.
// s_tready is high whenever the result register is empty or being drained, so a
// stalled m_tready holds the result and blocks input only while it stays low.
// arst_n clears all state, result valid, and loads the register reset values.
module button_gesture_blink_sequencer_top #(
	parameter int TIMER_WIDTH = 16
) (
	input  logic                            clk,
	input  logic                            arst_n,
	// slave stream
	input  logic                            s_tvalid,
	output logic                            s_tready,
	input  logic [bgbs_pkg::S_TDATA_W-1:0]  s_tdata,  // [0] button_level, [7:1] zero
	// master stream
	output logic                            m_tvalid,
	input  logic                            m_tready,
	output logic [bgbs_pkg::M_TDATA_W-1:0]  m_tdata,  // [0] led_level, [2:1] mode,
	                                                  // [18:3] current_delay,
	                                                  // [20:19] delay_index, [21] reverse
	                                                  // [23:22] zero
	// config
	input  logic                            psel,
	input  logic                            penable,
	input  logic                            pwrite,
	input  logic [bgbs_pkg::APB_ADDR_W-1:0] paddr,
	input  logic [bgbs_pkg::APB_DATA_W-1:0] pwdata,
	output logic [bgbs_pkg::APB_DATA_W-1:0] prdata,
	output logic                            pready
);
	import bgbs_pkg::*;

	// wide enough to compare a timer against a 16-bit register either way
	localparam int CMP_W = (TIMER_WIDTH > DELAY_W) ? TIMER_WIDTH : DELAY_W;

	// config registers
	logic [DELAY_W-1:0] delay_q [NUM_DELAYS];
	logic [DELAY_W-1:0] hold_thr_q;
	logic [DELAY_W-1:0] click_gap_q;

	// gesture state
	logic                   led_q;
	logic [INDEX_W-1:0]     index_q;
	logic                   dir_down_q;
	logic                   prev_btn_q;
	logic [1:0]             clicks_q;
	logic                   holding_q;
	logic [TIMER_WIDTH-1:0] blink_el_q;
	logic [TIMER_WIDTH-1:0] press_el_q;
	logic [TIMER_WIDTH-1:0] click_el_q;
	logic [TIMER_WIDTH-1:0] hold_el_q;

	// next state
	logic                   led_d;
	logic [INDEX_W-1:0]     index_d;
	logic                   dir_down_d;
	logic [1:0]             clicks_d;
	logic                   holding_d;
	logic [TIMER_WIDTH-1:0] blink_el_d;
	logic [TIMER_WIDTH-1:0] press_el_d;
	logic [TIMER_WIDTH-1:0] click_el_d;
	logic [TIMER_WIDTH-1:0] hold_el_d;
	logic [DELAY_W-1:0]     period_blink;
	logic [DELAY_W-1:0]     period_hold;
	logic [DELAY_W-1:0]     period_out;
	mode_t                  mode_d;

	// result register
	logic                   out_valid_q;
	logic [M_TDATA_W-1:0]   out_data_q;

	logic btn;
	logic in_fire;
	logic cfg_wr;
	reg_idx_t cfg_idx;

	assign btn      = s_tdata[0];
	assign s_tready = !out_valid_q || m_tready;
	assign in_fire  = s_tvalid && s_tready;
	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_data_q;

	assign pready  = 1'b1;
	assign cfg_wr  = psel && penable && pwrite && pready;
	assign cfg_idx = reg_idx_t'(paddr[APB_ADDR_W-1:2]);

	always_comb begin
		prdata = '0;
		case (cfg_idx)
			REG_DELAY_0:   prdata = APB_DATA_W'(delay_q[0]);
			REG_DELAY_1:   prdata = APB_DATA_W'(delay_q[1]);
			REG_DELAY_2:   prdata = APB_DATA_W'(delay_q[2]);
			REG_DELAY_3:   prdata = APB_DATA_W'(delay_q[3]);
			REG_HOLD_THR:  prdata = APB_DATA_W'(hold_thr_q);
			REG_CLICK_GAP: prdata = APB_DATA_W'(click_gap_q);
			default:       prdata = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			delay_q[0]  <= DELAY_0_RST;
			delay_q[1]  <= DELAY_1_RST;
			delay_q[2]  <= DELAY_2_RST;
			delay_q[3]  <= DELAY_3_RST;
			hold_thr_q  <= HOLD_THR_RST;
			click_gap_q <= CLICK_GAP_RST;
		end else if (cfg_wr) begin
			case (cfg_idx)
				REG_DELAY_0:   delay_q[0]  <= pwdata[DELAY_W-1:0];
				REG_DELAY_1:   delay_q[1]  <= pwdata[DELAY_W-1:0];
				REG_DELAY_2:   delay_q[2]  <= pwdata[DELAY_W-1:0];
				REG_DELAY_3:   delay_q[3]  <= pwdata[DELAY_W-1:0];
				REG_HOLD_THR:  hold_thr_q  <= pwdata[DELAY_W-1:0];
				REG_CLICK_GAP: click_gap_q <= pwdata[DELAY_W-1:0];
				default: ;
			endcase
		end
	end

	// One tick, in the order: timers, blink, rise, fall, hold entry,
	// hold toggle, click resolve.
	always_comb begin
		led_d      = led_q;
		index_d    = index_q;
		dir_down_d = dir_down_q;
		clicks_d   = clicks_q;
		holding_d  = holding_q;

		// saturating timers
		blink_el_d = (&blink_el_q) ? blink_el_q : blink_el_q + 1'b1;
		press_el_d = (&press_el_q) ? press_el_q : press_el_q + 1'b1;
		click_el_d = (&click_el_q) ? click_el_q : click_el_q + 1'b1;
		hold_el_d  = (&hold_el_q)  ? hold_el_q  : hold_el_q  + 1'b1;

		// normal blink; only taken when not holding, so full period
		period_blink = delay_q[index_q];
		if (!holding_q && (CMP_W'(blink_el_d) >= CMP_W'(period_blink))) begin
			blink_el_d = '0;
			led_d      = !led_d;
			index_d    = next_index(index_d, dir_down_d);
		end

		// press edge
		if (btn && !prev_btn_q) begin
			press_el_d = '0;
			click_el_d = '0;
			if (clicks_d < CLICKS_MAX)
				clicks_d = clicks_d + 1'b1;
		end

		// release edge
		if (!btn && prev_btn_q) begin
			if (!holding_d)
				click_el_d = '0;
			holding_d = 1'b0;
		end

		// long press
		if (btn && !holding_d && (CMP_W'(press_el_d) >= CMP_W'(hold_thr_q))) begin
			holding_d = 1'b1;
			clicks_d  = '0;
			hold_el_d = '0;
		end

		// half-period toggle while holding
		period_hold = delay_q[index_d] >> 1;
		if (holding_d && (CMP_W'(hold_el_d) >= CMP_W'(period_hold))) begin
			hold_el_d = '0;
			led_d     = !led_d;
			index_d   = next_index(index_d, dir_down_d);
		end

		// click resolve once the gap has strictly passed
		if (!holding_d && (clicks_d != '0) && (CMP_W'(click_el_d) > CMP_W'(click_gap_q))) begin
			if (clicks_d == 2'd1)
				index_d = next_index(index_d, dir_down_d);
			else
				dir_down_d = !dir_down_d;
			clicks_d = '0;
		end

		if (holding_d)
			mode_d = GEST_HELD;
		else if (clicks_d == 2'd2)
			mode_d = GEST_TWO_CLICKS;
		else if (clicks_d == 2'd1)
			mode_d = GEST_ONE_CLICK;
		else
			mode_d = GEST_NONE;

		period_out = holding_d ? (delay_q[index_d] >> 1) : delay_q[index_d];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			led_q       <= 1'b0;
			index_q     <= '0;
			dir_down_q  <= 1'b0;
			prev_btn_q  <= 1'b0;
			clicks_q    <= '0;
			holding_q   <= 1'b0;
			blink_el_q  <= '0;
			press_el_q  <= '0;
			click_el_q  <= '0;
			hold_el_q   <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (in_fire) begin
				led_q      <= led_d;
				index_q    <= index_d;
				dir_down_q <= dir_down_d;
				prev_btn_q <= btn;
				clicks_q   <= clicks_d;
				holding_q  <= holding_d;
				blink_el_q <= blink_el_d;
				press_el_q <= press_el_d;
				click_el_q <= click_el_d;
				hold_el_q  <= hold_el_d;
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// result payload, no reset needed
	always_ff @(posedge clk) begin
		if (in_fire)
			out_data_q <= M_TDATA_W'({dir_down_d, index_d, period_out, mode_d, led_d});
	end

endmodule

[sv/bgbs_checker.sv]
module bgbs_checker (
	input logic                            clk,
	input logic                            arst_n,
	input logic                            s_tvalid,
	input logic                            s_tready,
	input logic                            m_tvalid,
	input logic                            m_tready,
	input logic [bgbs_pkg::M_TDATA_W-1:0]  m_tdata,
	input logic                            pready
);
	import bgbs_pkg::*;

	// a stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("result changed while stalled");

	// every accepted word yields a result next cycle
	a_one_result: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> m_tvalid)
		else $error("accepted word produced no result");

	// empty or draining output never blocks input
	a_no_bubble: assert property (@(posedge clk) disable iff (!arst_n)
		!m_tvalid || m_tready |-> s_tready)
		else $error("input blocked with free result slot");

	// padding bits stay zero
	a_pad_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> m_tdata[M_TDATA_W-1:M_FIELDS_W] == '0)
		else $error("nonzero padding in result");

	a_pready: assert property (@(posedge clk) disable iff (!arst_n) pready)
		else $error("pready low");

endmodule

bind button_gesture_blink_sequencer_top bgbs_checker u_bgbs_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.pready   (pready)
);

[test/tb_top.sv]
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	import bgbs_pkg::*;

	// word address 6: outside the register map, writes must be dropped
	localparam logic [2:0] REG_UNUSED = 3'd6;
	// cycles with no word moving on either stream before the run is declared hung
	localparam int STALL_LIMIT = 2000;
	// long press well past a small threshold, several hold toggles
	localparam int HOLD_RUN = 40;

	// result word fields, lowest bit last so the struct maps straight onto m_tdata
	typedef struct packed {
		logic               rev;
		logic [INDEX_W-1:0] index;
		logic [DELAY_W-1:0] delay;
		mode_t              mode;
		logic               led;
	} blink_word_t;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  s_tvalid = 1'b0;
	logic                  s_tready;
	logic [S_TDATA_W-1:0]  s_tdata = '0;  // [0] button_level, [7:1] zero
	logic                  m_tvalid;
	logic                  m_tready = 1'b0;
	logic [M_TDATA_W-1:0]  m_tdata;       // [0] led, [2:1] mode, [18:3] delay,
	                                      // [20:19] index, [21] reverse
	logic                  psel = 1'b0;
	logic                  penable = 1'b0;
	logic                  pwrite = 1'b0;
	logic [APB_ADDR_W-1:0] paddr = '0;
	logic [APB_DATA_W-1:0] pwdata = '0;
	logic [APB_DATA_W-1:0] prdata;
	logic                  pready;

	// button samples waiting to be sent, results waiting to be seen
	bit          button_q[$];
	blink_word_t blink_word_q[$];

	int   err_cnt = 0;
	int   src_gap = 0;
	int   sink_gap = 0;
	int   stall_cnt = 0;
	logic idle_en = 1'b1;

	// register copies, reset values from the package
	logic [DELAY_W-1:0] cfg_delay[NUM_DELAYS] = '{DELAY_0_RST, DELAY_1_RST,
		DELAY_2_RST, DELAY_3_RST};
	logic [DELAY_W-1:0] cfg_thr = HOLD_THR_RST;
	logic [DELAY_W-1:0] cfg_gap = CLICK_GAP_RST;

	// gesture state of the predictor
	logic               led_st = 1'b0;
	logic [INDEX_W-1:0] idx_st = '0;
	logic               dir_st = 1'b0;
	logic               prev_btn = 1'b0;
	logic               hold_st = 1'b0;
	logic [1:0]         clicks_st = '0;
	logic [DELAY_W-1:0] blink_t = '0;
	logic [DELAY_W-1:0] press_t = '0;
	logic [DELAY_W-1:0] click_t = '0;
	logic [DELAY_W-1:0] hold_t = '0;

	button_gesture_blink_sequencer_top uut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.psel     (psel),
		.penable  (penable),
		.pwrite   (pwrite),
		.paddr    (paddr),
		.pwdata   (pwdata),
		.prdata   (prdata),
		.pready   (pready)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	// ---------------------------------------------------------------- predictor

	function automatic logic [DELAY_W-1:0] sat_inc(input logic [DELAY_W-1:0] t);
		return (t == '1) ? t : t + 1'b1;
	endfunction

	// period at the current index, halved (floor) in hold
	function automatic logic [DELAY_W-1:0] active_delay();
		return hold_st ? (cfg_delay[idx_st] >> 1) : cfg_delay[idx_st];
	endfunction

	task automatic step_index();
		idx_st = dir_st ? idx_st - 1'b1 : idx_st + 1'b1;
	endtask

	// one tick: timers, blink, edges, hold, click resolution
	task automatic tick_gesture(input logic btn);
		blink_word_t w;
		blink_t = sat_inc(blink_t);
		press_t = sat_inc(press_t);
		click_t = sat_inc(click_t);
		hold_t  = sat_inc(hold_t);

		// normal blinking; the blink timer keeps running but is not checked in hold
		if (!hold_st && blink_t >= active_delay()) begin
			blink_t = '0;
			led_st  = ~led_st;
			step_index();
		end
		// press: count the click, saturating
		if (btn && !prev_btn) begin
			press_t = '0;
			click_t = '0;
			if (clicks_st < CLICKS_MAX)
				clicks_st = clicks_st + 1'b1;
		end
		// release: a release out of hold does not restart the click gap
		if (!btn && prev_btn) begin
			if (!hold_st)
				click_t = '0;
			hold_st = 1'b0;
		end
		if (btn && !hold_st && press_t >= cfg_thr) begin
			hold_st   = 1'b1;
			clicks_st = '0;
			hold_t    = '0;
		end
		// hold pacing; a halved period of zero toggles on every tick, entry tick too
		if (hold_st && hold_t >= active_delay()) begin
			hold_t = '0;
			led_st = ~led_st;
			step_index();
		end
		// gap strictly exceeded: one click steps, two reverse
		if (!hold_st && clicks_st != 0 && click_t > cfg_gap) begin
			if (clicks_st == 2'd1)
				step_index();
			else
				dir_st = ~dir_st;
			clicks_st = '0;
		end
		prev_btn = btn;

		if (hold_st)
			w.mode = GEST_HELD;
		else if (clicks_st == CLICKS_MAX)
			w.mode = GEST_TWO_CLICKS;
		else if (clicks_st == 2'd1)
			w.mode = GEST_ONE_CLICK;
		else
			w.mode = GEST_NONE;
		w.led   = led_st;
		w.delay = active_delay();
		w.index = idx_st;
		w.rev   = dir_st;
		blink_word_q.push_back(w);
	endtask

	// ------------------------------------------------------------------ driver
	// Sends one button word per handshake, with random idle bursts between words.
	// Prediction runs on the accepting edge, so it sees the config in force.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_tvalid <= 1'b0;
			s_tdata  <= '0;
			src_gap  <= 0;
		end else begin
			if (s_tvalid && s_tready)
				tick_gesture(s_tdata[0]);
			if (!s_tvalid || s_tready) begin
				if (src_gap != 0) begin
					s_tvalid <= 1'b0;
					src_gap  <= src_gap - 1;
				end else if (button_q.size() == 0) begin
					s_tvalid <= 1'b0;
				end else if (idle_en && $urandom_range(0, 9) == 0) begin
					s_tvalid <= 1'b0;
					src_gap  <= $urandom_range(0, 14);
				end else begin
					s_tvalid <= 1'b1;
					s_tdata  <= {{(S_TDATA_W-1){1'b0}}, button_q.pop_front()};
				end
			end
		end
	end

	// ----------------------------------------------------------------- monitor
	// Checks every accepted result word against the oldest prediction, and
	// throttles m_tready with random bursts of low cycles.
	always @(posedge clk or negedge arst_n) begin : mon
		blink_word_t got;
		blink_word_t want;
		if (!arst_n) begin
			m_tready <= 1'b0;
			sink_gap <= 0;
		end else begin
			if (m_tvalid && m_tready) begin
				got = blink_word_t'(m_tdata[M_FIELDS_W-1:0]);
				if (blink_word_q.size() == 0) begin
					$error("result word with nothing predicted: %h", m_tdata);
					err_cnt++;
				end else begin
					want = blink_word_q.pop_front();
					if (got.led !== want.led) begin
						$error("led_level: expected %0d, got %0d", want.led, got.led);
						err_cnt++;
					end
					if (got.mode !== want.mode) begin
						$error("mode: expected %0d, got %0d", want.mode, got.mode);
						err_cnt++;
					end
					if (got.delay !== want.delay) begin
						$error("current_delay: expected %0d, got %0d", want.delay, got.delay);
						err_cnt++;
					end
					if (got.index !== want.index) begin
						$error("delay_index: expected %0d, got %0d", want.index, got.index);
						err_cnt++;
					end
					if (got.rev !== want.rev) begin
						$error("reverse: expected %0d, got %0d", want.rev, got.rev);
						err_cnt++;
					end
				end
			end
			if (sink_gap != 0) begin
				m_tready <= 1'b0;
				sink_gap <= sink_gap - 1;
			end else if (idle_en && $urandom_range(0, 11) == 0) begin
				m_tready <= 1'b0;
				sink_gap <= $urandom_range(0, 14);
			end else begin
				m_tready <= 1'b1;
			end
		end
	end

	// ---------------------------------------------------------------- watchdog
	always @(posedge clk) begin
		if (arst_n) begin
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
				stall_cnt <= 0;
			else
				stall_cnt <= stall_cnt + 1;
			if (stall_cnt >= STALL_LIMIT) begin
				$display("TB_ERROR");
				$finish;
			end
		end
	end

	// ------------------------------------------------------------- config port

	// setup cycle, access cycle; pready is sampled on the access edge
	task automatic apb_access(input logic wr, input logic [2:0] idx,
			input logic [DELAY_W-1:0] val, output logic [DELAY_W-1:0] rd);
		@(posedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= wr;
		paddr   <= {idx, 2'b00};
		pwdata  <= {{(APB_DATA_W-DELAY_W){1'b0}}, val};
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready)
			@(posedge clk);
		rd = prdata[DELAY_W-1:0];
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
	endtask

	// write, update the local copy, read back
	task automatic cfg_set(input reg_idx_t r, input logic [DELAY_W-1:0] val);
		logic [DELAY_W-1:0] rd;
		apb_access(1'b1, r, val, rd);
		case (r)
			REG_HOLD_THR:  cfg_thr = val;
			REG_CLICK_GAP: cfg_gap = val;
			default:       cfg_delay[r[1:0]] = val;
		endcase
		apb_access(1'b0, r, '0, rd);
		if (rd !== val) begin
			$error("register %s readback: expected %0d, got %0d", r.name(), val, rd);
			err_cnt++;
		end
	endtask

	task automatic cfg_phase(input logic [DELAY_W-1:0] d0, input logic [DELAY_W-1:0] d1,
			input logic [DELAY_W-1:0] d2, input logic [DELAY_W-1:0] d3,
			input logic [DELAY_W-1:0] thr, input logic [DELAY_W-1:0] gap);
		cfg_set(REG_DELAY_0, d0);
		cfg_set(REG_DELAY_1, d1);
		cfg_set(REG_DELAY_2, d2);
		cfg_set(REG_DELAY_3, d3);
		cfg_set(REG_HOLD_THR, thr);
		cfg_set(REG_CLICK_GAP, gap);
	endtask

	// ---------------------------------------------------------------- stimulus

	task automatic push_level(input bit lvl, input int n);
		repeat (n) button_q.push_back(lvl);
	endtask

	// Well-formed gestures sized to the current threshold and gap, with some
	// noise mixed in. Lengths are capped so that huge settings stay short.
	task automatic gen_gestures(input int target);
		int stop_at;
		int short_max;
		int gap_len;
		int long_lo;
		int long_hi;
		stop_at   = button_q.size() + target;
		short_max = (cfg_thr > 30) ? 30 : cfg_thr;
		gap_len   = (cfg_gap > 60) ? 60 : cfg_gap;
		long_lo   = (cfg_thr > 200) ? 1 : cfg_thr;
		long_hi   = (cfg_thr > 200) ? 60 : cfg_thr + 40;
		while (button_q.size() < stop_at) begin
			case ($urandom_range(0, 9))
				0, 1, 2: begin  // lone click, let it resolve
					push_level(1'b1, $urandom_range(1, short_max));
					push_level(1'b0, $urandom_range(gap_len + 1, gap_len + 6));
				end
				3, 4: begin     // double click inside the gap
					push_level(1'b1, $urandom_range(1, short_max));
					push_level(1'b0, $urandom_range(1, gap_len + 1));
					push_level(1'b1, $urandom_range(1, short_max));
					push_level(1'b0, $urandom_range(1, gap_len + 6));
				end
				5, 6: begin     // long press into hold
					push_level(1'b1, $urandom_range(long_lo, long_hi));
					push_level(1'b0, $urandom_range(1, 10));
				end
				7: begin        // triple: clicks pile up and saturate
					repeat (3) begin
						push_level(1'b1, $urandom_range(1, short_max));
						push_level(1'b0, $urandom_range(1, gap_len + 1));
					end
				end
				8: begin        // raw noise
					repeat ($urandom_range(1, 12))
						button_q.push_back(1'($urandom_range(0, 1)));
				end
				default: push_level(1'b0, $urandom_range(1, 30));
			endcase
		end
	endtask

	// everything sent, every result seen, then a few cycles of margin
	task automatic drain();
		while (button_q.size() != 0 || s_tvalid || blink_word_q.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	initial begin : stim
		logic [DELAY_W-1:0] rd;
		bit   [0:23]        directed;

		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// write outside the map, must leave every register alone
		apb_access(1'b1, REG_UNUSED, 16'h0001, rd);

		// directed at reset settings: clicks, double, saturating triple, press edges
		directed = 24'b0101_0100_1101_0001_1101_0100;
		foreach (directed[i])
			button_q.push_back(directed[i]);
		drain();

		// reset settings: threshold 100, gap 50, slow blinking
		gen_gestures(200);
		drain();

		for (int p = 0; p < 8; p++) begin
			case (p)
				0: cfg_phase('1, '1, '1, '1, '1, '1);        // all at maximum
				1: cfg_phase(16'd1, 16'd1, 16'd1, 16'd1, 16'd1, '0); // delays and threshold at 1, gap at 0
				5: cfg_phase(DELAY_W'($urandom_range(1, 65535)),
					DELAY_W'($urandom_range(1, 65535)),
					DELAY_W'($urandom_range(1, 65535)),
					DELAY_W'($urandom_range(1, 65535)),
					DELAY_W'($urandom_range(1, 40)), DELAY_W'($urandom_range(0, 20)));
				default: cfg_phase(DELAY_W'($urandom_range(1, 24)),
					DELAY_W'($urandom_range(1, 24)),
					DELAY_W'($urandom_range(1, 24)),
					DELAY_W'($urandom_range(1, 24)),
					DELAY_W'($urandom_range(1, 40)), DELAY_W'($urandom_range(0, 20)));
			endcase
			gen_gestures(85);
			drain();
		end

		// last part, no idling: a long press into hold, release, then gestures
		idle_en = 1'b0;
		cfg_phase(16'd3, 16'd5, 16'd7, 16'd9, 16'd4, 16'd2);
		push_level(1'b1, HOLD_RUN);
		push_level(1'b0, 20);
		gen_gestures(40);
		drain();

		repeat (8) @(posedge clk);
		if (blink_word_q.size() != 0) begin
			$error("%0d result words never arrived", blink_word_q.size());
			err_cnt++;
		end
		if (err_cnt == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

endmodule
